>>> hw/rtl/sdfg_pkg.sv
// Package for the slow data frame generator.
// Holds frame constants, register codes and the shared config and status types.
// No dependencies.
package sdfg_pkg;

    localparam int unsigned FRAMES         = 20;
    localparam int unsigned HDR_LEN        = 41;
    localparam int unsigned CRC_LEN        = HDR_LEN - 2;
    localparam int unsigned GROUP_BYTES    = 5;
    localparam int unsigned GROUP_BITS     = 8 * GROUP_BYTES;
    localparam int unsigned HDR_GROUPS     = 9;
    localparam int unsigned TXT_GROUPS     = 4;
    localparam int unsigned HDR_VEC_BYTES  = HDR_GROUPS * GROUP_BYTES;

    localparam logic [7:0]  PAD_BYTE       = 8'h66;
    localparam logic [7:0]  SPACE_BYTE     = 8'h20;
    localparam logic [7:0]  HDR_TYPE_BASE  = 8'h50;
    localparam logic [7:0]  TXT_TYPE_BASE  = 8'h40;
    localparam logic [7:0]  SCR_BYTE0      = 8'h70;
    localparam logic [7:0]  SCR_BYTE1      = 8'h4F;
    localparam logic [7:0]  SCR_BYTE2      = 8'h93;
    // "CQCQCQ  ", first character in the low byte
    localparam logic [63:0] UR_FIELD       = 64'h2020_5143_5143_5143;

    localparam logic [15:0] CRC_INIT       = 16'hFFFF;
    localparam logic [15:0] CRC_POLY       = 16'h8408;

    typedef logic [GROUP_BITS-1:0]      t_group;
    typedef logic [8*HDR_VEC_BYTES-1:0] t_hdr_vec;

    typedef enum logic [2:0] {
        CFG_MY,
        CFG_RPT1,
        CFG_RPT2,
        CFG_HDR_LOADED,
        CFG_TXT_LOW,
        CFG_TXT_MID,
        CFG_TXT_HIGH,
        CFG_TXT_EN
    } t_cfg_idx;

    typedef struct packed {
        logic [63:0] my;
        logic [63:0] rpt1;
        logic [63:0] rpt2;
        logic        hdr_loaded;
        logic [63:0] txt_low;
        logic [63:0] txt_mid;
        logic [31:0] txt_high;
        logic        txt_en;
    } t_cfg;

    typedef struct packed {
        logic        busy;
        logic [15:0] crc;
    } t_crc_status;

    // Header bytes, byte i at bits [8i+7:8i], padded out to whole groups.
    function automatic t_hdr_vec hdr_bytes(input t_cfg cfg, input logic [15:0] crc);
        hdr_bytes = {{(HDR_VEC_BYTES - HDR_LEN){PAD_BYTE}}, crc, {4{SPACE_BYTE}},
                     cfg.my, UR_FIELD, cfg.rpt1, cfg.rpt2, 24'h000000};
    endfunction

endpackage

>>> hw/rtl/sdfg_crc.sv
// Byte-serial X.25 CRC over the first 39 header bytes.
// Uses sdfg_pkg; reruns after reset and after every callsign write.
module sdfg_crc (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  sdfg_pkg::t_cfg       i_cfg,
    input  logic                 i_restart,
    output sdfg_pkg::t_crc_status o_status
);
    import sdfg_pkg::*;

    localparam logic [5:0] CNT_LAST = 6'(CRC_LEN - 1);

    logic        r_busy, n_busy;
    logic [5:0]  r_cnt, n_cnt;
    logic [15:0] r_crc, n_crc;
    t_hdr_vec    hv;
    logic [7:0]  cur_byte;

    function automatic logic [15:0] crc_byte(input logic [15:0] c, input logic [7:0] b);
        logic [15:0] x;
        x = c ^ {8'h00, b};
        for (int i = 0; i < 8; i++) begin
            x = x[0] ? ((x >> 1) ^ CRC_POLY) : (x >> 1);
        end
        return x;
    endfunction

    assign hv       = hdr_bytes(i_cfg, 16'h0000);
    assign cur_byte = hv[{r_cnt, 3'b000} +: 8];

    always_comb begin
        n_busy = r_busy;
        n_cnt  = r_cnt;
        n_crc  = r_crc;
        if (i_restart) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_crc  = CRC_INIT;
        end else if (r_busy) begin
            n_crc = crc_byte(r_crc, cur_byte);
            n_cnt = r_cnt + 6'd1;
            if (r_cnt == CNT_LAST) begin
                n_busy = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
            r_crc  <= CRC_INIT;
        end else begin
            r_busy <= n_busy;
            r_cnt  <= n_cnt;
            r_crc  <= n_crc;
        end
    end

    assign o_status.busy = r_busy;
    assign o_status.crc  = ~r_crc;

    a_restart_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_restart |=> (r_busy && r_cnt == 6'd0))
        else $error("crc pass did not restart");

    a_pass_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && !i_restart && r_cnt == CNT_LAST) |=> !r_busy)
        else $error("crc pass overran its last byte");

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_cnt <= CNT_LAST))
        else $error("crc byte count out of range");

endmodule

>>> hw/rtl/sdfg_frame.sv
// Slot byte selection for one voice frame: header or text group, type byte, scrambling.
// Uses sdfg_pkg; purely combinational.
module sdfg_frame (
    input  logic           i_frame_number_q,
    input  logic [4:0]     i_fn,
    input  sdfg_pkg::t_cfg i_cfg,
    input  logic [15:0]    i_crc,
    output logic [7:0]     o_byte0,
    output logic [7:0]     o_byte1,
    output logic [7:0]     o_byte2
);
    import sdfg_pkg::*;

    logic [4:0]   idx;
    logic [3:0]   g;
    logic         odd, in_range, txt_mode, hdr_mode, has_data;
    t_hdr_vec     hv;
    logic [159:0] tv;
    t_group       hdr_grp [HDR_GROUPS];
    t_group       txt_grp [TXT_GROUPS];
    t_group       grp;
    logic [7:0]   type_byte, raw0, raw1, raw2;

    // i_frame_number_q carries the superframe parity bit
    assign hv = hdr_bytes(i_cfg, i_crc);
    assign tv = {i_cfg.txt_high, i_cfg.txt_mid, i_cfg.txt_low};

    for (genvar j = 0; j < HDR_GROUPS; j++) begin : g_hdr
        assign hdr_grp[j] = hv[GROUP_BITS*j +: GROUP_BITS];
    end
    for (genvar j = 0; j < TXT_GROUPS; j++) begin : g_txt
        assign txt_grp[j] = tv[GROUP_BITS*j +: GROUP_BITS];
    end

    always_comb begin
        idx       = i_fn - 5'd1;
        g         = idx[4:1];
        odd       = idx[0];
        in_range  = (i_fn != 5'd0) && (i_fn <= 5'(FRAMES));
        txt_mode  = in_range && i_cfg.txt_en && !i_frame_number_q;
        hdr_mode  = in_range && !txt_mode && i_cfg.hdr_loaded;
        grp       = {GROUP_BYTES{PAD_BYTE}};
        type_byte = PAD_BYTE;
        has_data  = 1'b0;
        if (txt_mode && g < 4'(TXT_GROUPS)) begin
            grp       = txt_grp[g[1:0]];
            type_byte = TXT_TYPE_BASE + {4'h0, g};
            has_data  = 1'b1;
        end else if (hdr_mode && g < 4'(HDR_GROUPS)) begin
            grp       = hdr_grp[g];
            type_byte = HDR_TYPE_BASE + {4'h0, g};
            has_data  = 1'b1;
        end

        // first frame of a pair: type, d0, d1; second: d2, d3, d4
        if (!has_data) begin
            raw0 = PAD_BYTE;
            raw1 = PAD_BYTE;
            raw2 = PAD_BYTE;
        end else if (!odd) begin
            raw0 = type_byte;
            raw1 = grp[7:0];
            raw2 = grp[15:8];
        end else begin
            raw0 = grp[23:16];
            raw1 = grp[31:24];
            raw2 = grp[39:32];
        end

        if (txt_mode || hdr_mode) begin
            o_byte0 = raw0 ^ SCR_BYTE0;
            o_byte1 = raw1 ^ SCR_BYTE1;
            o_byte2 = raw2 ^ SCR_BYTE2;
        end else begin
            o_byte0 = raw0;
            o_byte1 = raw1;
            o_byte2 = raw2;
        end
    end

endmodule

>>> hw/rtl/slow_data_frame_generator.sv
// Slow data frame generator: three slow-data bytes per voice frame beat.
// Input beats pass an input register and then a result register; throughput one
// beat per cycle, set by the single-pass selection logic, when no CRC pass runs
// and the output is free. The header CRC is built one byte a cycle; no input
// beat is taken during its pass after reset and each callsign write. Reset is
// synchronous, active low, and clears all config registers and pipeline valids.
module slow_data_frame_generator (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [4:0] i_frame_number,
    input  logic       i_superframe_parity,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [7:0] o_slot_byte0,
    output logic [7:0] o_slot_byte1,
    output logic [7:0] o_slot_byte2,
    input  logic       i_cfg_we,
    input  logic [2:0] i_cfg_index,
    input  logic [63:0] i_cfg_data
);
    import sdfg_pkg::*;

    t_cfg        r_cfg;
    t_crc_status crc_st;
    logic        crc_restart;

    logic        r_in_valid;
    logic [4:0]  r_fn;
    logic        r_par;
    logic        r_out_valid;
    logic [7:0]  r_b0, r_b1, r_b2;
    logic [7:0]  n_b0, n_b1, n_b2;
    logic        out_free, advance, in_take;

    // config writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_MY:         r_cfg.my         <= i_cfg_data;
                CFG_RPT1:       r_cfg.rpt1       <= i_cfg_data;
                CFG_RPT2:       r_cfg.rpt2       <= i_cfg_data;
                CFG_HDR_LOADED: r_cfg.hdr_loaded <= i_cfg_data[0];
                CFG_TXT_LOW:    r_cfg.txt_low    <= i_cfg_data;
                CFG_TXT_MID:    r_cfg.txt_mid    <= i_cfg_data;
                CFG_TXT_HIGH:   r_cfg.txt_high   <= i_cfg_data[31:0];
                CFG_TXT_EN:     r_cfg.txt_en     <= i_cfg_data[0];
            endcase
        end
    end

    assign crc_restart = i_cfg_we && (t_cfg_idx'(i_cfg_index) == CFG_MY ||
                                      t_cfg_idx'(i_cfg_index) == CFG_RPT1 ||
                                      t_cfg_idx'(i_cfg_index) == CFG_RPT2);

    sdfg_crc u_crc (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_restart (crc_restart),
        .o_status  (crc_st)
    );

    sdfg_frame u_frame (
        .i_frame_number_q (r_par),
        .i_fn             (r_fn),
        .i_cfg            (r_cfg),
        .i_crc            (crc_st.crc),
        .o_byte0          (n_b0),
        .o_byte1          (n_b1),
        .o_byte2          (n_b2)
    );

    assign out_free = !r_out_valid || i_ready;
    assign advance  = r_in_valid && out_free;
    assign o_ready  = !crc_st.busy && (!r_in_valid || advance);
    assign in_take  = i_valid && o_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_take) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_fn  <= i_frame_number;
            r_par <= i_superframe_parity;
        end
        if (advance) begin
            r_b0 <= n_b0;
            r_b1 <= n_b1;
            r_b2 <= n_b2;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_slot_byte0 = r_b0;
    assign o_slot_byte1 = r_b1;
    assign o_slot_byte2 = r_b2;

    a_no_take_during_crc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        crc_st.busy |-> !o_ready)
        else $error("beat taken while header crc in progress");

    a_beat_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_take |=> r_in_valid)
        else $error("accepted beat lost from input register");

    a_out_of_range_raw: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && (r_fn == 5'd0 || r_fn > 5'(FRAMES))) |=>
        (r_b0 == PAD_BYTE && r_b1 == PAD_BYTE && r_b2 == PAD_BYTE))
        else $error("invalid frame number did not give raw filler");

endmodule

>>> tb/sv/tb_top.sv
// Self-checking bench for the slow data frame generator: header, text and filler
// frames predicted from a shadow of the register file, checked beat by beat.
// Depends on sdfg_pkg and slow_data_frame_generator.
module tb_top;
    import sdfg_pkg::*;

    typedef logic [2:0][7:0] t_slot;
    typedef logic [7:0] t_hdr_arr [HDR_VEC_BYTES];

    localparam t_slot       SCRAMBLE = {8'h93, 8'h4F, 8'h70};
    localparam logic [63:0] CQ_CALL  = "CQCQCQ  ";

    logic        clk;
    logic        rst_n = 1'b0;
    logic        frame_valid = 1'b0;
    logic        frame_ready;
    logic [4:0]  frame_number = '0;
    logic        superframe_parity = 1'b0;
    logic        slot_valid;
    logic        slot_ready = 1'b0;
    logic [7:0]  slot_byte0, slot_byte1, slot_byte2;
    logic        cfg_we = 1'b0;
    logic [2:0]  cfg_index = '0;
    logic [63:0] cfg_data = '0;

    t_cfg  shadow = '0;
    t_slot pending_slots [$];
    int    send_idle_pct = 0;
    int    recv_stall_pct = 0;
    int    stall_cycles = 0;
    int    mismatch_count = 0;
    int    frames_sent = 0;
    int    slots_checked = 0;
    int    settings_written = 0;

    slow_data_frame_generator dut (
        .i_clk               (clk),
        .i_rst_n             (rst_n),
        .i_valid             (frame_valid),
        .o_ready             (frame_ready),
        .i_frame_number      (frame_number),
        .i_superframe_parity (superframe_parity),
        .o_valid             (slot_valid),
        .i_ready             (slot_ready),
        .o_slot_byte0        (slot_byte0),
        .o_slot_byte1        (slot_byte1),
        .o_slot_byte2        (slot_byte2),
        .i_cfg_we            (cfg_we),
        .i_cfg_index         (cfg_index),
        .i_cfg_data          (cfg_data)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial begin
        #3000000;
        $display("*** FAILED ***");
        $finish;
    end

    // Header image with CRC, padded with 0x66 to whole groups
    function automatic t_hdr_arr header_bytes();
        t_hdr_arr h;
        logic [15:0] crc;
        int i, b;
        crc = 16'hFFFF;
        for (i = 0; i < HDR_VEC_BYTES; i++) h[i] = PAD_BYTE;
        for (i = 0; i < 3; i++) h[i] = 8'h00;
        for (i = 0; i < 8; i++) begin
            h[3 + i]  = shadow.rpt2[8*i +: 8];
            h[11 + i] = shadow.rpt1[8*i +: 8];
            h[19 + i] = CQ_CALL[8*(7-i) +: 8];
            h[27 + i] = shadow.my[8*i +: 8];
        end
        for (i = 35; i < 39; i++) h[i] = 8'h20;
        for (i = 0; i < 39; i++) begin
            crc = crc ^ {8'h00, h[i]};
            for (b = 0; b < 8; b++)
                crc = crc[0] ? ((crc >> 1) ^ 16'h8408) : (crc >> 1);
        end
        crc = ~crc;
        h[39] = crc[7:0];
        h[40] = crc[15:8];
        return h;
    endfunction

    function automatic logic [7:0] text_char_at(input int k);
        if (k < 8) return shadow.txt_low[8*k +: 8];
        if (k < 16) return shadow.txt_mid[8*(k-8) +: 8];
        return shadow.txt_high[8*(k-16) +: 8];
    endfunction

    function automatic t_slot slow_bytes_for(input logic [4:0] fn, input logic par);
        t_slot      raw;
        t_hdr_arr   hdr;
        logic [7:0] grp [5];
        logic [7:0] type_byte;
        logic       scramble, have_group;
        int         idx, g, k;
        raw = {3{PAD_BYTE}};
        scramble = 1'b0;
        have_group = 1'b0;
        type_byte = '0;
        if (fn >= 1 && fn <= 20) begin
            idx = fn - 1;
            g = idx / 2;
            if (shadow.txt_en && !par) begin
                scramble = 1'b1;
                if (g < TXT_GROUPS) begin
                    have_group = 1'b1;
                    type_byte = TXT_TYPE_BASE + 8'(g);
                    for (k = 0; k < 5; k++) grp[k] = text_char_at(g*5 + k);
                end
            end else if (shadow.hdr_loaded) begin
                scramble = 1'b1;
                if (g < HDR_GROUPS) begin
                    have_group = 1'b1;
                    type_byte = HDR_TYPE_BASE + 8'(g);
                    hdr = header_bytes();
                    for (k = 0; k < 5; k++) grp[k] = hdr[g*5 + k];
                end
            end
            // first frame of a group leads with the type byte
            if (have_group)
                raw = (idx % 2) ? {grp[4], grp[3], grp[2]} : {grp[1], grp[0], type_byte};
        end
        return scramble ? (raw ^ SCRAMBLE) : raw;
    endfunction

    function automatic logic [4:0] random_frame();
        if ($urandom_range(0, 9) != 0) return 5'($urandom_range(1, 20));
        return 5'($urandom_range(0, 31));
    endfunction

    // Receiver: long hold-off when asked, otherwise random stalls
    always @(posedge clk) begin
        if (stall_cycles > 0) begin
            slot_ready <= 1'b0;
            stall_cycles--;
        end else begin
            slot_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    always @(posedge clk) begin
        t_slot want, got;
        got = {slot_byte2, slot_byte1, slot_byte0};
        if (rst_n && slot_valid && slot_ready) begin
            slots_checked++;
            if (pending_slots.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected result beat %h %h %h", got[0], got[1], got[2]);
            end else begin
                want = pending_slots.pop_front();
                for (int k = 0; k < 3; k++) begin
                    if (got[k] !== want[k]) begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                            $display("slot_byte%0d mismatch at result %0d: expected %h, got %h",
                                     k, slots_checked, want[k], got[k]);
                    end
                end
            end
        end
    end

    task automatic send_frame(input logic [4:0] fn, input logic par);
        if ($urandom_range(0, 99) < send_idle_pct) begin
            frame_valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(0, 99) < send_idle_pct);
        end
        frame_valid       <= 1'b1;
        frame_number      <= fn;
        superframe_parity <= par;
        do @(posedge clk); while (!frame_ready);
        pending_slots.push_back(slow_bytes_for(fn, par));
        frames_sent++;
    endtask

    // Drain, let the pipe settle, then wait out any CRC pass
    task automatic wait_idle();
        frame_valid <= 1'b0;
        while (pending_slots.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
        while (!frame_ready) @(posedge clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [63:0] value);
        wait_idle();
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
        case (idx)
            CFG_MY:         shadow.my = value;
            CFG_RPT1:       shadow.rpt1 = value;
            CFG_RPT2:       shadow.rpt2 = value;
            CFG_HDR_LOADED: shadow.hdr_loaded = value[0];
            CFG_TXT_LOW:    shadow.txt_low = value;
            CFG_TXT_MID:    shadow.txt_mid = value;
            CFG_TXT_HIGH:   shadow.txt_high = value[31:0];
            CFG_TXT_EN:     shadow.txt_en = value[0];
            default: ;
        endcase
        settings_written++;
    endtask

    task automatic set_idling(input int mode);
        case (mode)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 84; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 84; end
            default: begin send_idle_pct = 14; recv_stall_pct = 14; end
        endcase
    endtask

    // Reset state: out-of-range frames and an unloaded header give raw pad bytes
    task automatic test_reset_defaults();
        send_frame(5'd0, 1'b0);
        send_frame(5'd0, 1'b1);
        send_frame(5'd21, 1'b0);
        send_frame(5'd31, 1'b1);
        send_frame(5'd1, 1'b1);
        send_frame(5'd6, 1'b0);
    endtask

    task automatic test_header_frames();
        write_reg(CFG_MY,   64'h2020_3132_4B41_5447);
        write_reg(CFG_RPT1, 64'h4220_3133_4A44_5746);
        write_reg(CFG_RPT2, 64'h4720_3133_4A44_5746);
        write_reg(CFG_HDR_LOADED, 64'd1);
        send_frame(5'd1, 1'b1);
        send_frame(5'd2, 1'b1);
        send_frame(5'd17, 1'b1);
        send_frame(5'd18, 1'b1);
        send_frame(5'd19, 1'b1);
        send_frame(5'd20, 1'b0);
    endtask

    // Text on an even superframe goes out even with the header unloaded
    task automatic test_text_frames();
        write_reg(CFG_HDR_LOADED, 64'd0);
        write_reg(CFG_TXT_LOW,  64'h4847_4645_4443_4241);
        write_reg(CFG_TXT_MID,  64'h504F_4E4D_4C4B_4A49);
        write_reg(CFG_TXT_HIGH, 64'h5453_5251);
        write_reg(CFG_TXT_EN,   64'd1);
        send_frame(5'd1, 1'b0);
        send_frame(5'd2, 1'b0);
        send_frame(5'd7, 1'b0);
        send_frame(5'd8, 1'b0);
        send_frame(5'd9, 1'b0);
        send_frame(5'd20, 1'b0);
        send_frame(5'd3, 1'b1);
    endtask

    task automatic test_random_rounds();
        logic [63:0] fill;
        for (int r = 0; r < 8; r++) begin
            set_idling(r % 4);
            for (int reg_i = 0; reg_i < 8; reg_i++) begin
                if (r == 3) fill = '1;
                else if (r == 4) fill = '0;
                else fill = {$urandom, $urandom};
                case (t_cfg_idx'(reg_i))
                    CFG_HDR_LOADED: write_reg(CFG_HDR_LOADED, 64'(r[2] ^ r[0]));
                    CFG_TXT_EN:     write_reg(CFG_TXT_EN, 64'(r[2] ^ r[1]));
                    default:        write_reg(t_cfg_idx'(reg_i), fill);
                endcase
            end
            repeat (140) send_frame(random_frame(), 1'($urandom_range(0, 1)));
        end
    endtask

    // Long output hold-off with the input kept busy, so the block backs up
    task automatic test_output_stall();
        write_reg(CFG_HDR_LOADED, 64'd1);
        write_reg(CFG_TXT_EN, 64'd1);
        set_idling(0);
        stall_cycles = 300;
        repeat (40) send_frame(random_frame(), 1'($urandom_range(0, 1)));
        wait_idle();
    endtask

    initial begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        test_reset_defaults();
        test_header_frames();
        test_text_frames();
        test_random_rounds();
        test_output_stall();
        wait_idle();
        repeat (10) @(posedge clk);
        $display("%0d frames sent, %0d result beats checked, %0d register writes,",
                 frames_sent, slots_checked, settings_written);
        $display("covering header, text and pad frames under four idle mixes and a long stall");
        if (mismatch_count == 0 && pending_slots.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
